### rtl/core/ir_pulse_packet_parser_core_macros.svh
// Assertion macros for the IR packet parser port-level checker, irpp_checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef IR_PULSE_PACKET_PARSER_CORE_MACROS_SVH
`define IR_PULSE_PACKET_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define IRPP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define IRPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/irpp_pkg.sv
// Package for the IR pulse packet parser: parser state, status codes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irpp_pkg;

  // Special byte values of the packet stream
  localparam logic [7:0]  SYNC_BYTE    = 8'hff;
  localparam logic [7:0]  STOP_BYTE    = 8'hfe;
  localparam logic [7:0]  DUTY_MAX     = 8'd100;
  localparam logic [6:0]  DUTY_RESET   = 7'd50;
  localparam logic [31:0] CARRIER_PERIOD_RESET = 32'd1263;
  localparam logic [31:0] PERIOD_NONE  = 32'hffff_ffff;

  // Field widths
  localparam int unsigned WIDTH_W   = 31;
  localparam int unsigned PERIOD_W  = 32;
  localparam int unsigned ASM_W     = 23;

  // Status reported with every result
  typedef enum logic [1:0] {
    STATUS_NONE   = 2'd0,
    STATUS_REPEAT = 2'd1,
    STATUS_STOP   = 2'd2,
    STATUS_WIDTH  = 2'd3
  } status_t;

  // Parser state, one-hot
  typedef enum logic [11:0] {
    ST_SYNC    = 12'b0000_0000_0001,
    ST_REPEAT  = 12'b0000_0000_0010,
    ST_DUTY    = 12'b0000_0000_0100,
    ST_CAR_HI  = 12'b0000_0000_1000,
    ST_CAR_LO  = 12'b0000_0001_0000,
    ST_P_FIRST = 12'b0000_0010_0000,
    ST_P_WLOW  = 12'b0000_0100_0000,
    ST_P_L2    = 12'b0000_1000_0000,
    ST_P_L3    = 12'b0001_0000_0000,
    ST_P_L4    = 12'b0010_0000_0000,
    ST_CHECK   = 12'b0100_0000_0000,
    ST_RECOVER = 12'b1000_0000_0000
  } parse_state_t;

endpackage : irpp_pkg

`default_nettype wire

### rtl/core/irpp_ifs.sv
// Valid/ready channel interfaces for the IR packet parser: byte in, result out.
// Depends on irpp_pkg for status_t and field widths.
`timescale 1ns / 1ps
`default_nettype none

interface irpp_in_if import irpp_pkg::*; ;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface : irpp_in_if

interface irpp_out_if import irpp_pkg::*; ;
  logic                valid;
  logic                ready;
  logic                pulse_valid;
  logic                pulse_level;
  logic [WIDTH_W-1:0]  pulse_width;
  logic [7:0]          repeat_count;
  logic [6:0]          duty_cycle;
  logic [PERIOD_W-1:0] carrier_period;
  status_t             cmd_status;
  logic                checksum_ok;

  modport source (output valid, output pulse_valid, output pulse_level,
                  output pulse_width, output repeat_count, output duty_cycle,
                  output carrier_period, output cmd_status, output checksum_ok,
                  input ready);
  modport sink   (input valid, input pulse_valid, input pulse_level,
                  input pulse_width, input repeat_count, input duty_cycle,
                  input carrier_period, input cmd_status, input checksum_ok,
                  output ready);
endinterface : irpp_out_if

`default_nettype wire

### rtl/core/ir_pulse_packet_parser_core.sv
// IR transmit packet parser: one byte in, one result item out per byte.
// Depends on irpp_pkg and the channel interfaces in irpp_ifs.sv.
//
// Usage:
//   in_ch  carries one received byte of the packet stream per item.
//   out_ch carries one result item per accepted byte: the pulse completed by
//          that byte (if any), the current repeat count, duty cycle, carrier
//          period, status and checksum flag, all as they stand after the byte.
// The result for a byte is registered and appears in the cycle after it is accepted.
// Throughput: one byte per cycle while the result side is not stalled; the parser
//   state and the result register are both updated in the accepting cycle by a single level of decode.
// Stalls: the result register holds its item while out_ch.ready is low; a new
//   byte is still taken in any cycle where that register is empty or is being
//   emptied, so in_ch.ready = !out valid || out_ch.ready.
// Reset (synchronous, active low): parser waits for a sync byte, duty cycle
//   50, carrier period 1263, repeat count 0, status none, checksum cleared,
//   result register empty.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_packet_parser_core
  import irpp_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  irpp_in_if.sink     in_ch,
  irpp_out_if.source  out_ch
);

  // Parser state
  parse_state_t        state_r,   state_nxt;
  logic [7:0]          xor_r,     xor_nxt;
  logic                ck_seen_r, ck_seen_nxt;
  logic [ASM_W-1:0]    asm_r,     asm_nxt;
  logic                level_r,   level_nxt;
  logic [7:0]          repeat_r,  repeat_nxt;
  logic [6:0]          duty_r,    duty_nxt;
  logic [PERIOD_W-1:0] period_r,  period_nxt;
  status_t             status_r,  status_nxt;

  // Result register
  logic                out_valid_r;
  logic                res_pv_r,  res_pv_nxt;
  logic                res_pl_r,  res_pl_nxt;
  logic [WIDTH_W-1:0]  res_pw_r,  res_pw_nxt;
  logic                res_ck_r;

  logic                in_accept;
  logic [7:0]          b;
  logic [12:0]         car_w;
  logic [WIDTH_W-1:0]  pulse_w;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  // Carrier width is eighth-microsecond units, divided by 8
  assign car_w   = {asm_r[7:0], b[7:3]};
  // Pulse width; the long-form flag bit has already been shifted out
  assign pulse_w = {asm_r, b};

  // Byte decode
  always_comb begin
    state_nxt   = state_r;
    xor_nxt     = xor_r;
    ck_seen_nxt = ck_seen_r;
    asm_nxt     = asm_r;
    level_nxt   = level_r;
    repeat_nxt  = repeat_r;
    duty_nxt    = duty_r;
    period_nxt  = period_r;
    status_nxt  = status_r;
    res_pv_nxt  = 1'b0;
    res_pl_nxt  = 1'b0;
    res_pw_nxt  = '0;
    case (state_r)
      ST_SYNC: begin
        if (b == SYNC_BYTE) begin
          state_nxt = ST_REPEAT;
        end
      end
      ST_REPEAT: begin
        // further sync bytes are skipped
        if (b != SYNC_BYTE) begin
          xor_nxt     = b;
          ck_seen_nxt = 1'b0;
          if (b == STOP_BYTE) begin
            status_nxt = STATUS_STOP;
            state_nxt  = ST_CHECK;
          end else begin
            repeat_nxt = b;
            status_nxt = STATUS_REPEAT;
            state_nxt  = ST_DUTY;
          end
        end
      end
      ST_DUTY: begin
        if (b <= DUTY_MAX) begin
          xor_nxt   = xor_r ^ b;
          duty_nxt  = b[6:0];
          state_nxt = ST_CAR_HI;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CAR_HI: begin
        if (b != SYNC_BYTE) begin
          xor_nxt   = xor_r ^ b;
          asm_nxt   = {{(ASM_W-8){1'b0}}, b};
          state_nxt = ST_CAR_LO;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CAR_LO: begin
        xor_nxt    = xor_r ^ b;
        period_nxt = (car_w == '0) ? PERIOD_NONE : {{(PERIOD_W-13){1'b0}}, car_w};
        level_nxt  = 1'b1;
        state_nxt  = ST_P_FIRST;
      end
      ST_P_FIRST: begin
        // a sync byte here ends the width list
        if (b == SYNC_BYTE) begin
          status_nxt = STATUS_WIDTH;
          state_nxt  = ST_CHECK;
        end else begin
          xor_nxt   = xor_r ^ b;
          asm_nxt   = {{(ASM_W-8){1'b0}}, b};
          state_nxt = b[7] ? ST_P_L2 : ST_P_WLOW;
        end
      end
      ST_P_WLOW, ST_P_L4: begin
        xor_nxt    = xor_r ^ b;
        res_pv_nxt = 1'b1;
        res_pl_nxt = level_r;
        res_pw_nxt = pulse_w;
        level_nxt  = !level_r;
        state_nxt  = ST_P_FIRST;
      end
      ST_P_L2: begin
        xor_nxt   = xor_r ^ b;
        asm_nxt   = {asm_r[ASM_W-9:0], b};
        state_nxt = ST_P_L3;
      end
      ST_P_L3: begin
        // the long-form flag bit falls off the top here
        xor_nxt   = xor_r ^ b;
        asm_nxt   = {asm_r[ASM_W-9:0], b};
        state_nxt = ST_P_L4;
      end
      ST_CHECK: begin
        xor_nxt     = xor_r ^ b;
        ck_seen_nxt = 1'b1;
        state_nxt   = ST_SYNC;
      end
      ST_RECOVER: begin
        if (b == SYNC_BYTE) begin
          state_nxt = ST_SYNC;
        end
      end
      default: begin
        state_nxt = ST_RECOVER;
      end
    endcase
  end

  // Parser state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SYNC;
      xor_r       <= '0;
      ck_seen_r   <= 1'b0;
      asm_r       <= '0;
      level_r     <= 1'b0;
      repeat_r    <= '0;
      duty_r      <= DUTY_RESET;
      period_r    <= CARRIER_PERIOD_RESET;
      status_r    <= STATUS_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r   <= state_nxt;
        xor_r     <= xor_nxt;
        ck_seen_r <= ck_seen_nxt;
        asm_r     <= asm_nxt;
        level_r   <= level_nxt;
        repeat_r  <= repeat_nxt;
        duty_r    <= duty_nxt;
        period_r  <= period_nxt;
        status_r  <= status_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pulse and checksum part of the result item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_pv_r <= res_pv_nxt;
      res_pl_r <= res_pl_nxt;
      res_pw_r <= res_pw_nxt;
      res_ck_r <= ck_seen_nxt && (xor_nxt == 8'h00);
    end
  end

  // Settings are shown straight from the state registers, which only move
  // when the next item is accepted
  assign out_ch.valid          = out_valid_r;
  assign out_ch.pulse_valid    = res_pv_r;
  assign out_ch.pulse_level    = res_pl_r;
  assign out_ch.pulse_width    = res_pw_r;
  assign out_ch.repeat_count   = repeat_r;
  assign out_ch.duty_cycle     = duty_r;
  assign out_ch.carrier_period = period_r;
  assign out_ch.cmd_status     = status_r;
  assign out_ch.checksum_ok    = res_ck_r;

endmodule : ir_pulse_packet_parser_core

`default_nettype wire

### rtl/core/irpp_checker.sv
// Port-level checks for ir_pulse_packet_parser_core, bound into that module.
// Depends on irpp_pkg and ir_pulse_packet_parser_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "ir_pulse_packet_parser_core_macros.svh"

module irpp_checker
  import irpp_pkg::*;
(
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_ready,
  input wire                out_valid,
  input wire                out_ready,
  input wire                pulse_valid,
  input wire                pulse_level,
  input wire [WIDTH_W-1:0]  pulse_width,
  input wire [6:0]          duty_cycle,
  input wire [PERIOD_W-1:0] carrier_period
);

  // A stalled result item keeps its pulse width and carrier period
  `IRPP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(pulse_width) && $stable(carrier_period), "result item changed while stalled")

  // Every accepted byte gives a result item in the next cycle
  `IRPP_ASSERT_NEXT(a_item_result, in_valid && in_ready, out_valid, "accepted byte gave no result item")

  // Without a completed pulse, level and width read as zero
  `IRPP_ASSERT_SAME(a_no_pulse_zero, out_valid && !pulse_valid, !pulse_level && (pulse_width == '0), "pulse fields set without a pulse")

  // The stored duty cycle never exceeds the accepted maximum
  `IRPP_ASSERT_SAME(a_duty_range, out_valid, {1'b0, duty_cycle} <= DUTY_MAX, "duty cycle above maximum")

endmodule : irpp_checker

bind ir_pulse_packet_parser_core irpp_checker u_irpp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .pulse_valid    (out_ch.pulse_valid),
  .pulse_level    (out_ch.pulse_level),
  .pulse_width    (out_ch.pulse_width),
  .duty_cycle     (out_ch.duty_cycle),
  .carrier_period (out_ch.carrier_period)
);

`default_nettype wire

### test/irpp_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the IR pulse packet parser: it predicts each result item
// and compares it field by field. It depends on irpp_pkg and the channel interfaces.

module irpp_result_checker
  import irpp_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  irpp_in_if   in_mon,
  irpp_out_if  out_mon,
  output int   err_count,
  output int   pending,
  output int   results_seen
);

  // Layout of one predicted result item
  typedef struct packed {
    logic               pulse_valid;
    logic               pulse_level;
    logic [WIDTH_W-1:0] pulse_width;
    logic [7:0]         repeat_count;
    logic [6:0]         duty_cycle;
    logic [31:0]        carrier_period;
    status_t            cmd_status;
    logic               checksum_ok;
  } parse_result_t;

  // Shadow of the parser state
  parse_state_t  ps;
  logic [7:0]    run_xor;
  logic          sum_seen;
  logic [31:0]   word;
  logic          lvl;
  logic [7:0]    rep;
  logic [6:0]    duty;
  logic [31:0]   period;
  status_t       status;

  parse_result_t predicted_results[$];
  parse_result_t oldest;
  int            errs = 0;
  int            seen = 0;

  // Take one byte into the shadow parser, return the result it should give
  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t r;
    r = '0;
    case (ps)
      ST_SYNC: begin
        if (b == SYNC_BYTE) ps = ST_REPEAT;
      end
      ST_REPEAT: begin
        // another 0xff is just more sync
        if (b != SYNC_BYTE) begin
          run_xor  = b;
          sum_seen = 1'b0;
          if (b == STOP_BYTE) begin
            status = STATUS_STOP;
            ps     = ST_CHECK;
          end else begin
            rep    = b;
            status = STATUS_REPEAT;
            ps     = ST_DUTY;
          end
        end
      end
      ST_DUTY: begin
        // out-of-range duty aborts without touching the checksum
        if (b <= DUTY_MAX) begin
          run_xor ^= b;
          duty     = b[6:0];
          ps       = ST_CAR_HI;
        end else begin
          ps = ST_CHECK;
        end
      end
      ST_CAR_HI: begin
        if (b != SYNC_BYTE) begin
          run_xor ^= b;
          word     = {24'd0, b};
          ps       = ST_CAR_LO;
        end else begin
          ps = ST_CHECK;
        end
      end
      ST_CAR_LO: begin
        run_xor ^= b;
        word     = {16'd0, word[7:0], b} >> 3;
        period   = (word == 32'd0) ? PERIOD_NONE : word;
        lvl      = 1'b1;
        ps       = ST_P_FIRST;
      end
      ST_P_FIRST: begin
        if (b == SYNC_BYTE) begin
          status = STATUS_WIDTH;
          ps     = ST_CHECK;
        end else begin
          run_xor ^= b;
          word     = {24'd0, b};
          ps       = b[7] ? ST_P_L2 : ST_P_WLOW;
        end
      end
      ST_P_WLOW, ST_P_L4: begin
        run_xor        ^= b;
        word            = {word[23:0], b};
        r.pulse_valid   = 1'b1;
        r.pulse_level   = lvl;
        r.pulse_width   = word[WIDTH_W-1:0];
        // long form drops its marker bit
        if (ps == ST_P_L4) word[31] = 1'b0;
        lvl = ~lvl;
        ps  = ST_P_FIRST;
      end
      ST_P_L2: begin
        run_xor ^= b;
        word     = {word[23:0], b};
        ps       = ST_P_L3;
      end
      ST_P_L3: begin
        run_xor ^= b;
        word     = {word[23:0], b};
        ps       = ST_P_L4;
      end
      ST_CHECK: begin
        run_xor ^= b;
        sum_seen = 1'b1;
        ps       = ST_SYNC;
      end
      default: begin
        // recovery: hold until a sync byte
        if (b == SYNC_BYTE) ps = ST_SYNC;
      end
    endcase
    r.repeat_count   = rep;
    r.duty_cycle     = duty;
    r.carrier_period = period;
    r.cmd_status     = status;
    r.checksum_ok    = sum_seen && (run_xor == 8'd0);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endfunction

  // Results are handled before bytes: a result leaving at this edge belongs to
  // an earlier byte.
  always @(posedge clk) begin
    if (!rst_n) begin
      ps       = ST_SYNC;
      run_xor  = '0;
      sum_seen = 1'b0;
      word     = '0;
      lvl      = 1'b0;
      rep      = '0;
      duty     = DUTY_RESET;
      period   = CARRIER_PERIOD_RESET;
      status   = STATUS_NONE;
      predicted_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen++;
        if (predicted_results.size() == 0) begin
          $error("result item arrived with no prediction pending");
          errs++;
        end else begin
          oldest = predicted_results.pop_front();
          check_field("pulse_valid", oldest.pulse_valid, out_mon.pulse_valid);
          check_field("pulse_level", oldest.pulse_level, out_mon.pulse_level);
          check_field("pulse_width", oldest.pulse_width, out_mon.pulse_width);
          check_field("repeat_count", oldest.repeat_count, out_mon.repeat_count);
          check_field("duty_cycle", oldest.duty_cycle, out_mon.duty_cycle);
          check_field("carrier_period", oldest.carrier_period, out_mon.carrier_period);
          check_field("cmd_status", oldest.cmd_status, out_mon.cmd_status);
          check_field("checksum_ok", oldest.checksum_ok, out_mon.checksum_ok);
        end
      end
      if (in_mon.valid && in_mon.ready)
        predicted_results.push_back(parse_byte(in_mon.rx_byte));
    end
    err_count    <= errs;
    pending      <= predicted_results.size();
    results_seen <= seen;
  end

endmodule : irpp_result_checker

### test/tb_ir_pulse_packet_parser_core.sv
`timescale 1ns / 1ps
// Testbench top for ir_pulse_packet_parser_core: drives packet bytes and result
// back-pressure with random idling. It depends on irpp_pkg, the interfaces and irpp_result_checker.

module tb_ir_pulse_packet_parser_core;
  import irpp_pkg::*;

  localparam int N_ITEMS     = 2000;
  localparam int MAX_GAP     = 18;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  logic clk;
  logic rst_n;

  irpp_in_if  in_ch ();
  irpp_out_if out_ch ();

  int err_count;
  int pending;
  int results_seen;

  int bytes_sent   = 0;
  int packets      = 0;
  int stop_pkts    = 0;
  int trunc_pkts   = 0;
  int stall_cycles = 0;
  bit no_idle      = 1'b0;

  logic [7:0] pkt[$];
  logic [7:0] pkt_xor = '0;

  ir_pulse_packet_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  irpp_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .err_count    (err_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle cycles before the next item on either side
  function automatic int draw_gap();
    int g;
    g = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    return g;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Packet assembly; in_sum marks bytes the parser folds into its XOR
  task automatic add(input logic [7:0] b, input bit in_sum);
    pkt.push_back(b);
    if (in_sum) pkt_xor ^= b;
  endtask

  task automatic flush_packet();
    foreach (pkt[i]) send_byte(pkt[i]);
    pkt.delete();
    pkt_xor = '0;
  endtask

  // Pulse run: short and long widths, ended by a sync byte
  task automatic add_pulses();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 1) == 1) begin
        add(8'($urandom_range(0, 127)), 1'b1);
        add(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        add(8'($urandom_range(128, 254)), 1'b1);
        repeat (3) add(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    add(SYNC_BYTE, 1'b0);
  endtask

  // Mostly well-formed packets with random content, plus stop commands, aborts, bad
  // checksums, truncated packets and line noise
  task automatic build_packet();
    int cut;
    packets++;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 4)) add(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      repeat ($urandom_range(1, 3)) add(SYNC_BYTE, 1'b0);
      if ($urandom_range(0, 9) == 0) begin
        stop_pkts++;
        add(STOP_BYTE, 1'b1);
      end else begin
        add(8'($urandom_range(0, 253)), 1'b1);
        if ($urandom_range(0, 9) == 0) begin
          add(8'($urandom_range(101, 255)), 1'b0);
        end else begin
          add(8'($urandom_range(0, 100)), 1'b1);
          case ($urandom_range(0, 11))
            0: add(SYNC_BYTE, 1'b0);
            1: begin
              // carrier width that divides down to zero
              add(8'h00, 1'b1);
              add(8'($urandom_range(0, 7)), 1'b1);
              add_pulses();
            end
            default: begin
              add(8'($urandom_range(0, 254)), 1'b1);
              add(8'($urandom_range(0, 255)), 1'b1);
              add_pulses();
            end
          endcase
        end
      end
      add(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : pkt_xor, 1'b0);
      if ($urandom_range(0, 9) == 0) begin
        trunc_pkts++;
        cut = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
    end
  endtask

  // Result side back-pressure
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // stray byte before sync, doubled sync, all-zero settings (period saturates),
    // zero pulse, long pulse carrying 0xff data, end of widths, good checksum
    add(8'h00, 1'b0);
    add(SYNC_BYTE, 1'b0);
    add(SYNC_BYTE, 1'b0);
    repeat (6) add(8'h00, 1'b1);
    add(8'hfe, 1'b1);
    repeat (3) add(SYNC_BYTE, 1'b1);
    add(SYNC_BYTE, 1'b0);
    add(pkt_xor, 1'b0);
    flush_packet();

    // stop command with good checksum
    add(SYNC_BYTE, 1'b0);
    add(STOP_BYTE, 1'b1);
    add(pkt_xor, 1'b0);
    flush_packet();

    // largest repeat count, duty just out of range, bad checksum
    add(SYNC_BYTE, 1'b0);
    add(8'd253, 1'b1);
    add(8'd101, 1'b0);
    add(8'h00, 1'b0);
    flush_packet();

    // full duty, then carrier high byte aborts
    add(SYNC_BYTE, 1'b0);
    add(8'd7, 1'b1);
    add(DUTY_MAX, 1'b1);
    add(SYNC_BYTE, 1'b0);
    add(pkt_xor, 1'b0);
    flush_packet();

    while (bytes_sent < N_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      build_packet();
      flush_packet();
    end
    in_ch.valid <= 1'b0;

    // drain, then give the block time to show anything extra
    @(posedge clk);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d packets (%0d stop, %0d cut short)",
             bytes_sent, packets, stop_pkts, trunc_pkts);
    $display("Compared %0d result items with the predicted parser output", results_seen);
    if (err_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule : tb_ir_pulse_packet_parser_core
